>>> hw/rtl/jti_pkg.sv
// ----------------------------------------------------------------------------
// jti_pkg
// Types, codes and character classes shared by the JSON token indexer.
// ----------------------------------------------------------------------------
package jti_pkg;

    // result kind codes
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_LENGTH = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // byte ranges
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;
    localparam logic [7:0] CONT_LO  = 8'd128;
    localparam logic [7:0] CONT_HI  = 8'd191;
    localparam logic [7:0] LEAD2_LO = 8'd192;
    localparam logic [7:0] LEAD2_HI = 8'd223;
    localparam logic [7:0] LEAD3_LO = 8'd224;
    localparam logic [7:0] LEAD3_HI = 8'd239;
    localparam logic [7:0] LEAD4_LO = 8'd240;
    localparam logic [7:0] LEAD4_HI = 8'd247;

    // one result item
    typedef struct packed {
        logic [1:0]        kind;
        logic [15:0]       value;
        logic              parse_error;
        logic signed [7:0] final_depth;
        logic              run_last;
    } t_result;

    // results produced by one step, token result first
    typedef struct packed {
        logic    tok_valid;
        t_result tok;
        logic    stat_valid;
        t_result stat;
    } t_push;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) || (b == CH_SPACE);
    endfunction

    function automatic logic is_bare_start(input logic [7:0] b);
        return (b == CH_MINUS) || ((b >= CH_ZERO) && (b <= CH_NINE)) ||
               (b == CH_LO_T) || (b == CH_LO_F) || (b == CH_LO_N);
    endfunction

    function automatic logic is_bare_end(input logic [7:0] b);
        return is_ws(b) || (b == CH_COMMA) || (b == CH_RBRACK) || (b == CH_RBRACE);
    endfunction

    function automatic logic is_esc_char(input logic [7:0] b);
        return (b == CH_QUOTE) || (b == CH_BSLASH) || (b == CH_SLASH) ||
               (b == CH_LO_B) || (b == CH_LO_F) || (b == CH_LO_N) ||
               (b == CH_LO_R) || (b == CH_LO_T) || (b == CH_LO_U);
    endfunction

endpackage

>>> hw/rtl/jti_if.sv
// ----------------------------------------------------------------------------
// jti_if
// Valid/ready channels of the JSON token indexer: byte input and result output.
// ----------------------------------------------------------------------------
interface jti_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface jti_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [15:0]       value;
    logic              parse_error;
    logic signed [7:0] final_depth;
    logic              run_last;

    modport source (output valid, output kind, output value, output parse_error,
                    output final_depth, output run_last, input ready);
    modport sink   (input valid, input kind, input value, input parse_error,
                    input final_depth, input run_last, output ready);
endinterface

>>> hw/rtl/jti_step.sv
// ----------------------------------------------------------------------------
// jti_step
// Scanner state and the one-byte update: mode change, depth, position,
// start offsets and lengths of depth-one values, end-of-document status.
// ----------------------------------------------------------------------------
module jti_step #(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic               i_eot,
    output jti_pkg::t_push     o_push
);

    localparam logic [2:0] MODE_STRUCT = 3'd0;
    localparam logic [2:0] MODE_BARE   = 3'd1;
    localparam logic [2:0] MODE_STRING = 3'd2;
    localparam logic [2:0] MODE_ESC    = 3'd3;
    localparam logic [2:0] MODE_UTF8   = 3'd4;

    logic [2:0]            r_mode,  n_mode;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    logic [1:0]            r_left,  n_left;
    logic [POS_BITS-1:0]   r_pos,   n_pos;
    logic [POS_BITS-1:0]   r_last,  n_last;
    logic                  r_err,   n_err;

    logic                  w_depth_one;
    logic                  w_do_struct;
    logic                  w_bad;
    logic                  w_tok_valid;
    logic [1:0]            w_tok_kind;
    logic [POS_BITS-1:0]   w_tok_val;
    logic [DEPTH_BITS-1:0] w_end_depth;
    logic                  w_end_err;

    assign w_depth_one = (r_depth == DEPTH_BITS'(1));

    // next state for one byte
    always_comb begin
        n_mode      = r_mode;
        n_depth     = r_depth;
        n_left      = r_left;
        n_last      = r_last;
        w_do_struct = 1'b0;
        w_bad       = 1'b0;
        w_tok_valid = 1'b0;
        w_tok_kind  = jti_pkg::KIND_START;
        w_tok_val   = r_last;

        if (!r_err) begin
            unique case (r_mode)
                MODE_BARE: begin
                    if (jti_pkg::is_bare_end(i_byte)) begin
                        // word ends here, the byte is then structure
                        if (w_depth_one) begin
                            w_tok_valid = 1'b1;
                            w_tok_kind  = jti_pkg::KIND_LENGTH;
                            w_tok_val   = r_pos - r_last;
                        end
                        n_mode      = MODE_STRUCT;
                        w_do_struct = 1'b1;
                    end else if ((i_byte < jti_pkg::PRINT_LO) ||
                                 (i_byte > jti_pkg::PRINT_HI)) begin
                        w_bad = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (i_byte == jti_pkg::CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else if (i_byte == jti_pkg::CH_QUOTE) begin
                        if (w_depth_one) begin
                            w_tok_valid = 1'b1;
                            w_tok_kind  = jti_pkg::KIND_LENGTH;
                            w_tok_val   = r_pos - r_last;
                        end
                        n_mode = MODE_STRUCT;
                    end else if ((i_byte >= jti_pkg::PRINT_LO) &&
                                 (i_byte <= jti_pkg::PRINT_HI)) begin
                        n_mode = MODE_STRING;
                    end else if ((i_byte >= jti_pkg::LEAD2_LO) &&
                                 (i_byte <= jti_pkg::LEAD2_HI)) begin
                        n_left = 2'd1;
                        n_mode = MODE_UTF8;
                    end else if ((i_byte >= jti_pkg::LEAD3_LO) &&
                                 (i_byte <= jti_pkg::LEAD3_HI)) begin
                        n_left = 2'd2;
                        n_mode = MODE_UTF8;
                    end else if ((i_byte >= jti_pkg::LEAD4_LO) &&
                                 (i_byte <= jti_pkg::LEAD4_HI)) begin
                        n_left = 2'd3;
                        n_mode = MODE_UTF8;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
                MODE_ESC: begin
                    if (jti_pkg::is_esc_char(i_byte)) begin
                        n_mode = MODE_STRING;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
                MODE_UTF8: begin
                    if ((i_byte >= jti_pkg::CONT_LO) && (i_byte <= jti_pkg::CONT_HI)) begin
                        if (r_left <= 2'd1) begin
                            n_left = 2'd0;
                            n_mode = MODE_STRING;
                        end else begin
                            n_left = r_left - 2'd1;
                        end
                    end else begin
                        w_bad = 1'b1;
                    end
                end
                default: begin
                    n_mode      = MODE_STRUCT;
                    w_do_struct = 1'b1;
                end
            endcase

            // structure byte; a word ended at depth one never closes back to one
            if (w_do_struct) begin
                if (jti_pkg::is_ws(i_byte) || (i_byte == jti_pkg::CH_COLON) ||
                    (i_byte == jti_pkg::CH_COMMA)) begin
                    n_mode = MODE_STRUCT;
                end else if (i_byte == jti_pkg::CH_QUOTE) begin
                    if (w_depth_one) begin
                        w_tok_valid = 1'b1;
                        w_tok_kind  = jti_pkg::KIND_START;
                        w_tok_val   = r_pos + POS_BITS'(1);
                    end
                    n_mode = MODE_STRING;
                end else if ((i_byte == jti_pkg::CH_LBRACK) ||
                             (i_byte == jti_pkg::CH_LBRACE)) begin
                    if (w_depth_one) begin
                        w_tok_valid = 1'b1;
                        w_tok_kind  = jti_pkg::KIND_START;
                        w_tok_val   = r_pos;
                    end
                    n_depth = r_depth + DEPTH_BITS'(1);
                end else if ((i_byte == jti_pkg::CH_RBRACK) ||
                             (i_byte == jti_pkg::CH_RBRACE)) begin
                    n_depth = r_depth - DEPTH_BITS'(1);
                    if (r_depth == DEPTH_BITS'(2)) begin
                        w_tok_valid = 1'b1;
                        w_tok_kind  = jti_pkg::KIND_LENGTH;
                        w_tok_val   = r_pos + POS_BITS'(1) - r_last;
                    end
                end else if (jti_pkg::is_bare_start(i_byte)) begin
                    if (w_depth_one) begin
                        w_tok_valid = 1'b1;
                        w_tok_kind  = jti_pkg::KIND_START;
                        w_tok_val   = r_pos;
                    end
                    n_mode = MODE_BARE;
                end else begin
                    w_bad = 1'b1;
                end
            end

            if (w_tok_valid) begin
                n_last = w_tok_val;
            end
        end

        n_err       = r_err | w_bad;
        n_pos       = r_pos + POS_BITS'(1);
        w_end_depth = n_depth;
        w_end_err   = n_err;

        // end of document: state back to reset values
        if (i_eot) begin
            n_mode  = MODE_STRUCT;
            n_depth = '0;
            n_left  = 2'd0;
            n_pos   = '0;
            n_last  = '0;
            n_err   = 1'b0;
        end
    end

    // results of this byte
    always_comb begin
        o_push.tok_valid        = w_tok_valid;
        o_push.tok.kind         = w_tok_kind;
        o_push.tok.value        = 16'(w_tok_val);
        o_push.tok.parse_error  = 1'b0;
        o_push.tok.final_depth  = '0;
        o_push.tok.run_last     = !i_eot;
        o_push.stat_valid       = i_eot;
        o_push.stat.kind        = jti_pkg::KIND_STATUS;
        o_push.stat.value       = '0;
        o_push.stat.parse_error = w_end_err;
        o_push.stat.final_depth = 8'($signed(w_end_depth));
        o_push.stat.run_last    = 1'b1;
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_STRUCT;
            r_depth <= '0;
            r_left  <= 2'd0;
            r_pos   <= '0;
            r_last  <= '0;
            r_err   <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_last  <= n_last;
            r_err   <= n_err;
        end
    end

    // end of document leaves a cleared scanner
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eot) |=> (r_mode == MODE_STRUCT && r_depth == '0 &&
                               r_pos == '0 && !r_err))
        else $error("scanner state not cleared after end of document");

    // after an error only the position moves
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_err && !i_eot) |=> ($stable(r_mode) && $stable(r_depth) &&
                                         $stable(r_last) && r_err))
        else $error("scanner state moved after an error");

    // a token result never comes while an error is latched
    a_err_no_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_push.tok_valid)
        else $error("token result after an error");

endmodule

>>> hw/rtl/jti_result_queue.sv
// ----------------------------------------------------------------------------
// jti_result_queue
// Four-entry result queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module jti_result_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_en,
    input  jti_pkg::t_push     i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output jti_pkg::t_result   o_head
);

    jti_pkg::t_result r_mem [4];
    logic [1:0]       r_wr_ptr, n_wr_ptr;
    logic [1:0]       r_rd_ptr, n_rd_ptr;
    logic [2:0]       r_count,  n_count;

    logic             w_tok_en;
    logic             w_stat_en;
    logic             w_pop;
    logic [1:0]       w_stat_ptr;

    assign w_tok_en   = i_push_en && i_push.tok_valid;
    assign w_stat_en  = i_push_en && i_push.stat_valid;
    assign w_pop      = o_valid && i_ready;
    assign w_stat_ptr = r_wr_ptr + {1'b0, w_tok_en};

    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointer and fill updates
    always_comb begin
        n_wr_ptr = r_wr_ptr + {1'b0, w_tok_en} + {1'b0, w_stat_en};
        n_rd_ptr = r_rd_ptr + {1'b0, w_pop};
        n_count  = r_count + {2'b0, w_tok_en} + {2'b0, w_stat_en} - {2'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // result storage, token result ahead of status
    always_ff @(posedge i_clk) begin
        if (w_tok_en) begin
            r_mem[r_wr_ptr] <= i_push.tok;
        end
        if (w_stat_en) begin
            r_mem[w_stat_ptr] <= i_push.stat;
        end
    end

    // fill level stays within the storage
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    // pushes only arrive with room for two
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok_en || w_stat_en) |-> (r_count <= 3'd2))
        else $error("result pushed without room");

endmodule

>>> hw/rtl/json_token_indexer.sv
// ----------------------------------------------------------------------------
// json_token_indexer
// Streams JSON text one byte per item and reports start offset and length of
// every depth-one value, plus a status item at the end of each document.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                            handshake
//  i_in     in   data_byte[7:0], end_of_text                        valid/ready
//  o_res    out  kind[1:0], value[15:0], parse_error,               valid/ready
//                final_depth[7:0] signed, run_last
//
//  one byte per cycle while the queue has room
//  a byte is registered, then scanned into a 4-entry result queue
//  the scan step waits only while the queue holds more than two results
//  a document's last byte gives up to two results, drained one per ready cycle
//  reset (i_rst_n low, synchronous) clears the scanner, input stage and queue
// ----------------------------------------------------------------------------
module json_token_indexer #(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jti_in_if.sink    i_in,
    jti_out_if.source o_res
);

    logic               r_in_valid;
    logic [7:0]         r_byte;
    logic               r_eot;

    logic               w_room;
    logic               w_fire;
    logic               w_accept;
    jti_pkg::t_push     w_push;
    jti_pkg::t_result   w_head;

    assign w_fire     = r_in_valid && w_room;
    assign i_in.ready = !r_in_valid || w_fire;
    assign w_accept   = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_in.data_byte;
            r_eot  <= i_in.end_of_text;
        end
    end

    // scanner
    jti_step #(
        .POS_BITS   (POS_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_byte),
        .i_eot   (r_eot),
        .o_push  (w_push)
    );

    // result queue
    jti_result_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (w_fire),
        .i_push    (w_push),
        .o_room    (w_room),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_head    (w_head)
    );

    assign o_res.kind        = w_head.kind;
    assign o_res.value       = w_head.value;
    assign o_res.parse_error = w_head.parse_error;
    assign o_res.final_depth = w_head.final_depth;
    assign o_res.run_last    = w_head.run_last;

    // a held byte blocks new input while the queue holds more than two results
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_room) |-> !i_in.ready)
        else $error("input taken while a byte is held");

    // an accepted byte is scanned no earlier than the next cycle
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in_valid)
        else $error("accepted byte lost");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks json_token_indexer against its own prediction of offsets, lengths
// and end-of-document status. A driver sends JSON bytes from a queue with
// random gaps, a monitor takes results with random stalls and compares each
// one field by field with the oldest predicted result. Stimulus covers short
// directed documents, random well-formed, broken and noise documents, and
// deep and unbalanced nesting.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [2:0] {
        M_STRUCT,
        M_BARE,
        M_STRING,
        M_ESC,
        M_UTF8
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } t_text_byte;

    logic i_clk;
    logic i_rst_n;

    jti_in_if  in_ch ();
    jti_out_if res_ch ();

    json_token_indexer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    // bytes waiting to be sent, results still due
    t_text_byte       text_q[$];
    jti_pkg::t_result results_due[$];
    jti_pkg::t_result byte_results[$];
    logic [7:0]       doc_buf[$];

    // predicted scanner state
    t_scan_mode  p_mode;
    logic [7:0]  p_depth;
    logic [1:0]  p_utf8;
    logic [15:0] p_pos;
    logic [15:0] p_last;
    logic        p_err;

    int         errors       = 0;
    int         queued       = 0;
    int         bytes_sent   = 0;
    int         results_seen = 0;
    int         cycle_count  = 0;
    int         stall_cycles = 0;
    logic       stall_on     = 1'b0;
    logic       send_gap;
    t_text_byte next_byte;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic logic is_space(input logic [7:0] b);
        return b == jti_pkg::CH_TAB || b == jti_pkg::CH_LF || b == jti_pkg::CH_CR ||
               b == jti_pkg::CH_SPACE;
    endfunction

    function automatic logic is_escape(input logic [7:0] b);
        return b == jti_pkg::CH_QUOTE || b == jti_pkg::CH_BSLASH ||
               b == jti_pkg::CH_SLASH || b == jti_pkg::CH_LO_B ||
               b == jti_pkg::CH_LO_F || b == jti_pkg::CH_LO_N ||
               b == jti_pkg::CH_LO_R || b == jti_pkg::CH_LO_T ||
               b == jti_pkg::CH_LO_U;
    endfunction

    function automatic void clear_scanner();
        p_mode  = M_STRUCT;
        p_depth = '0;
        p_utf8  = '0;
        p_pos   = '0;
        p_last  = '0;
        p_err   = 1'b0;
    endfunction

    function automatic void note(input logic [1:0] k, input logic [15:0] v);
        jti_pkg::t_result r;
        r       = '0;
        r.kind  = k;
        r.value = v;
        byte_results.push_back(r);
    endfunction

    // offsets and lengths only count at depth one
    function automatic void note_start(input logic [15:0] off);
        if (p_depth == 8'd1) begin
            p_last = p_pos + off;
            note(jti_pkg::KIND_START, p_last);
        end
    endfunction

    function automatic void note_length(input logic [15:0] plus);
        if (p_depth == 8'd1) begin
            p_last = p_pos + plus - p_last;
            note(jti_pkg::KIND_LENGTH, p_last);
        end
    endfunction

    // structure mode byte, returns 1 on an illegal byte
    function automatic logic struct_step(input logic [7:0] b);
        logic bad;
        bad = 1'b0;
        if (is_space(b) || b == jti_pkg::CH_COLON || b == jti_pkg::CH_COMMA) begin
            bad = 1'b0;
        end else if (b == jti_pkg::CH_QUOTE) begin
            note_start(16'd1);
            p_mode = M_STRING;
        end else if (b == jti_pkg::CH_LBRACK || b == jti_pkg::CH_LBRACE) begin
            note_start(16'd0);
            p_depth = p_depth + 8'd1;
        end else if (b == jti_pkg::CH_RBRACK || b == jti_pkg::CH_RBRACE) begin
            p_depth = p_depth - 8'd1;
            note_length(16'd1);
        end else if (b == jti_pkg::CH_MINUS ||
                     (b >= jti_pkg::CH_ZERO && b <= jti_pkg::CH_NINE) ||
                     b == jti_pkg::CH_LO_T || b == jti_pkg::CH_LO_F ||
                     b == jti_pkg::CH_LO_N) begin
            note_start(16'd0);
            p_mode = M_BARE;
        end else begin
            bad = 1'b1;
        end
        return bad;
    endfunction

    // one accepted byte: update state and queue the results it causes
    function automatic void index_byte(input logic [7:0] b, input logic eot);
        logic             bad;
        jti_pkg::t_result r;
        bad = 1'b0;
        byte_results.delete();
        if (!p_err) begin
            case (p_mode)
                M_BARE: begin
                    if (is_space(b) || b == jti_pkg::CH_COMMA ||
                        b == jti_pkg::CH_RBRACK || b == jti_pkg::CH_RBRACE) begin
                        note_length(16'd0);
                        p_mode = M_STRUCT;
                        bad    = struct_step(b);
                    end else if (b < jti_pkg::PRINT_LO || b > jti_pkg::PRINT_HI) begin
                        bad = 1'b1;
                    end
                end
                M_STRING: begin
                    if (b == jti_pkg::CH_BSLASH) begin
                        p_mode = M_ESC;
                    end else if (b == jti_pkg::CH_QUOTE) begin
                        note_length(16'd0);
                        p_mode = M_STRUCT;
                    end else if (b >= jti_pkg::PRINT_LO && b <= jti_pkg::PRINT_HI) begin
                        p_mode = M_STRING;
                    end else if (b >= jti_pkg::LEAD2_LO && b <= jti_pkg::LEAD2_HI) begin
                        p_utf8 = 2'd1;
                        p_mode = M_UTF8;
                    end else if (b >= jti_pkg::LEAD3_LO && b <= jti_pkg::LEAD3_HI) begin
                        p_utf8 = 2'd2;
                        p_mode = M_UTF8;
                    end else if (b >= jti_pkg::LEAD4_LO && b <= jti_pkg::LEAD4_HI) begin
                        p_utf8 = 2'd3;
                        p_mode = M_UTF8;
                    end else begin
                        bad = 1'b1;
                    end
                end
                M_ESC: begin
                    if (is_escape(b)) begin
                        p_mode = M_STRING;
                    end else begin
                        bad = 1'b1;
                    end
                end
                M_UTF8: begin
                    if (b >= jti_pkg::CONT_LO && b <= jti_pkg::CONT_HI) begin
                        if (p_utf8 <= 2'd1) begin
                            p_utf8 = 2'd0;
                            p_mode = M_STRING;
                        end else begin
                            p_utf8 = p_utf8 - 2'd1;
                        end
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    p_mode = M_STRUCT;
                    bad    = struct_step(b);
                end
            endcase
            if (bad) p_err = 1'b1;
        end

        p_pos = p_pos + 16'd1;

        // document status, then a fresh scanner
        if (eot) begin
            r             = '0;
            r.kind        = jti_pkg::KIND_STATUS;
            r.parse_error = p_err;
            r.final_depth = p_depth;
            byte_results.push_back(r);
            clear_scanner();
        end

        if (byte_results.size() != 0) begin
            r          = byte_results.pop_back();
            r.run_last = 1'b1;
            byte_results.push_back(r);
        end
        foreach (byte_results[i]) results_due.push_back(byte_results[i]);
    endfunction

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                index_byte(in_ch.data_byte, in_ch.end_of_text);
                bytes_sent++;
            end
            send_gap = !(bytes_sent >= 400 && bytes_sent < 800) &&
                       ($urandom_range(99) < 32);
            if (text_q.size() != 0 && !send_gap) begin
                next_byte         = text_q.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.data_byte   <= next_byte.data;
                in_ch.end_of_text <= next_byte.eot;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    function automatic void check_result(input jti_pkg::t_result got);
        jti_pkg::t_result want;
        if (results_due.size() == 0) begin
            $error("unexpected result: kind %0d value %0d", got.kind, got.value);
            errors++;
            return;
        end
        want = results_due.pop_front();
        if (got.kind != want.kind) begin
            $error("kind mismatch: expected %0d, got %0d", want.kind, got.kind);
            errors++;
        end
        if (got.value != want.value) begin
            $error("value mismatch: expected %0d, got %0d", want.value, got.value);
            errors++;
        end
        if (got.parse_error != want.parse_error) begin
            $error("parse_error mismatch: expected %0d, got %0d",
                   want.parse_error, got.parse_error);
            errors++;
        end
        if (got.final_depth != want.final_depth) begin
            $error("final_depth mismatch: expected %0d, got %0d",
                   $signed(want.final_depth), $signed(got.final_depth));
            errors++;
        end
        if (got.run_last != want.run_last) begin
            $error("run_last mismatch: expected %0d, got %0d", want.run_last, got.run_last);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        jti_pkg::t_result got;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.kind        = res_ch.kind;
                got.value       = res_ch.value;
                got.parse_error = res_ch.parse_error;
                got.final_depth = res_ch.final_depth;
                got.run_last    = res_ch.run_last;
                check_result(got);
                results_seen++;
            end
            // one long hold-off to back up the block, then random stalls
            if (stall_on && stall_cycles < 120) begin
                stall_cycles++;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= (results_seen >= 30 && results_seen < 130) ||
                                ($urandom_range(99) >= 32);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // document builders
    // ------------------------------------------------------------------------
    function automatic void flush_doc();
        t_text_byte it;
        if (doc_buf.size() == 0) doc_buf.push_back(jti_pkg::CH_SPACE);
        foreach (doc_buf[i]) begin
            it.data = doc_buf[i];
            it.eot  = (i == doc_buf.size() - 1);
            text_q.push_back(it);
        end
        queued += doc_buf.size();
        doc_buf.delete();
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) doc_buf.push_back(s[i]);
    endfunction

    function automatic void add_ws();
        int n;
        n = $urandom_range(2);
        repeat (n) begin
            case ($urandom_range(3))
                0:       doc_buf.push_back(jti_pkg::CH_TAB);
                1:       doc_buf.push_back(jti_pkg::CH_LF);
                2:       doc_buf.push_back(jti_pkg::CH_CR);
                default: doc_buf.push_back(jti_pkg::CH_SPACE);
            endcase
        end
    endfunction

    // quoted string with plain chars, escapes and utf-8 sequences
    function automatic void add_string();
        int         n;
        logic [7:0] c;
        doc_buf.push_back(jti_pkg::CH_QUOTE);
        n = $urandom_range(6);
        repeat (n) begin
            case ($urandom_range(9))
                6: begin
                    doc_buf.push_back(jti_pkg::CH_BSLASH);
                    case ($urandom_range(8))
                        0:       doc_buf.push_back(jti_pkg::CH_QUOTE);
                        1:       doc_buf.push_back(jti_pkg::CH_BSLASH);
                        2:       doc_buf.push_back(jti_pkg::CH_SLASH);
                        3:       doc_buf.push_back(jti_pkg::CH_LO_B);
                        4:       doc_buf.push_back(jti_pkg::CH_LO_F);
                        5:       doc_buf.push_back(jti_pkg::CH_LO_N);
                        6:       doc_buf.push_back(jti_pkg::CH_LO_R);
                        7:       doc_buf.push_back(jti_pkg::CH_LO_T);
                        default: doc_buf.push_back(jti_pkg::CH_LO_U);
                    endcase
                end
                7: begin
                    doc_buf.push_back(8'($urandom_range(jti_pkg::LEAD2_HI,
                                                        jti_pkg::LEAD2_LO)));
                    doc_buf.push_back(8'($urandom_range(jti_pkg::CONT_HI,
                                                        jti_pkg::CONT_LO)));
                end
                8: begin
                    doc_buf.push_back(8'($urandom_range(jti_pkg::LEAD3_HI,
                                                        jti_pkg::LEAD3_LO)));
                    repeat (2) doc_buf.push_back(8'($urandom_range(jti_pkg::CONT_HI,
                                                                   jti_pkg::CONT_LO)));
                end
                9: begin
                    doc_buf.push_back(8'($urandom_range(jti_pkg::LEAD4_HI,
                                                        jti_pkg::LEAD4_LO)));
                    repeat (3) doc_buf.push_back(8'($urandom_range(jti_pkg::CONT_HI,
                                                                   jti_pkg::CONT_LO)));
                end
                default: begin
                    do c = 8'($urandom_range(jti_pkg::PRINT_HI, jti_pkg::PRINT_LO));
                    while (c == jti_pkg::CH_QUOTE || c == jti_pkg::CH_BSLASH);
                    doc_buf.push_back(c);
                end
            endcase
        end
        doc_buf.push_back(jti_pkg::CH_QUOTE);
    endfunction

    function automatic void add_scalar();
        int n;
        case ($urandom_range(4))
            0: push_str("true");
            1: push_str("false");
            2: push_str("null");
            3: begin
                if ($urandom_range(1)) doc_buf.push_back(jti_pkg::CH_MINUS);
                n = $urandom_range(4, 1);
                repeat (n) doc_buf.push_back(8'($urandom_range(jti_pkg::CH_NINE,
                                                               jti_pkg::CH_ZERO)));
            end
            default: add_string();
        endcase
    endfunction

    function automatic void add_member_head(input logic obj, input logic first);
        if (!first) doc_buf.push_back(jti_pkg::CH_COMMA);
        add_ws();
        if (obj) begin
            add_string();
            add_ws();
            doc_buf.push_back(jti_pkg::CH_COLON);
            add_ws();
        end
    endfunction

    // array or object, members may hold one more level of scalars
    function automatic void add_container();
        logic obj;
        logic sub;
        int   n;
        int   m;
        obj = 1'($urandom_range(1));
        doc_buf.push_back(obj ? jti_pkg::CH_LBRACE : jti_pkg::CH_LBRACK);
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) begin
            add_member_head(obj, i == 0);
            if ($urandom_range(3) == 0) begin
                sub = 1'($urandom_range(1));
                doc_buf.push_back(sub ? jti_pkg::CH_LBRACE : jti_pkg::CH_LBRACK);
                m = $urandom_range(3);
                for (int j = 0; j < m; j++) begin
                    add_member_head(sub, j == 0);
                    add_scalar();
                    add_ws();
                end
                doc_buf.push_back(sub ? jti_pkg::CH_RBRACE : jti_pkg::CH_RBRACK);
            end else begin
                add_scalar();
            end
            add_ws();
        end
        doc_buf.push_back(obj ? jti_pkg::CH_RBRACE : jti_pkg::CH_RBRACK);
    endfunction

    // mostly well-formed documents, some broken, some plain noise
    task automatic queue_random(input int count);
        int target;
        int r;
        int n;
        target = queued + count;
        while (queued < target) begin
            r = $urandom_range(99);
            if (r < 15) begin
                n = $urandom_range(16, 1);
                repeat (n) doc_buf.push_back(8'($urandom_range(255)));
            end else begin
                add_ws();
                if ($urandom_range(3) != 0) add_container();
                else add_scalar();
                add_ws();
                if (r < 30 && doc_buf.size() > 1) begin
                    if ($urandom_range(1)) begin
                        doc_buf[$urandom_range(doc_buf.size() - 1)] = 8'($urandom_range(255));
                    end else begin
                        n = $urandom_range(doc_buf.size() - 1, 1);
                        while (doc_buf.size() > n) void'(doc_buf.pop_back());
                    end
                end
            end
            flush_doc();
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (text_q.size() != 0 || in_ch.valid || results_due.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.end_of_text  = 1'b0;
        res_ch.ready       = 1'b0;
        clear_scanner();

        // directed: negative number, escape, bare word closed by a brace
        push_str("[-7,\"\\t\"]");
        flush_doc();
        push_str("{\"\":t}");
        flush_doc();
        // array left open at end, widest utf-8 lead and continuation
        doc_buf.push_back(jti_pkg::CH_LBRACK);
        doc_buf.push_back(jti_pkg::CH_QUOTE);
        doc_buf.push_back(jti_pkg::LEAD4_HI);
        repeat (3) doc_buf.push_back(jti_pkg::CONT_HI);
        doc_buf.push_back(jti_pkg::CH_QUOTE);
        flush_doc();
        // an illegal byte, then a byte ignored after the error
        doc_buf.push_back(jti_pkg::CH_LBRACK);
        doc_buf.push_back(8'h00);
        doc_buf.push_back(8'hFF);
        flush_doc();
        // closer with nothing open
        push_str("]");
        flush_doc();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // random documents, the first batch under a long output stall
        stall_on = 1'b1;
        queue_random(300);
        wait_idle();
        queue_random(300);
        wait_idle();

        // deepest positive and negative depth
        repeat (127) doc_buf.push_back(jti_pkg::CH_LBRACK);
        flush_doc();
        repeat (128) doc_buf.push_back(jti_pkg::CH_LBRACK);
        flush_doc();
        // depth wraps around to one, string counts at depth one again
        repeat (255) doc_buf.push_back(jti_pkg::CH_RBRACK);
        push_str("\"x\"");
        flush_doc();
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/jti_pkg.sv
hw/rtl/jti_if.sv
hw/rtl/jti_step.sv
hw/rtl/jti_result_queue.sv
hw/rtl/json_token_indexer.sv
test/testbench.sv
